// File: src/ffa_pkg.sv
// Shared types and codes for the first-fit block allocator.
`default_nettype none
package ffa_pkg;

   localparam int STATUS_W = 3;
   localparam int REQ_W    = 12;
   localparam int PADDR_W  = 13;
   localparam int GRANT_W  = 12;

   localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_ASCAN,
      S_ISHIFT,
      S_IPUT,
      S_RSCAN,
      S_RNXT,
      S_RPRV,
      S_DSHIFT
   } state_type;

endpackage
`default_nettype wire

// File: src/ffa_if.sv
// Request and response channel interfaces.
`default_nettype none
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [ffa_pkg::REQ_W-1:0]   req_bytes;
   logic [ffa_pkg::PADDR_W-1:0] payload_addr;
   modport source (output valid, mode, req_bytes, payload_addr, input ready);
   modport sink (input valid, mode, req_bytes, payload_addr, output ready);
endinterface

interface ffa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffa_pkg::STATUS_W-1:0] status;
   logic [ffa_pkg::GRANT_W-1:0]  granted_addr;
   modport source (output valid, status, granted_addr, input ready);
   modport sink (input valid, status, granted_addr, output ready);
endinterface
`default_nettype wire

// File: src/first_fit_block_allocator_core.sv
// First-fit block allocator: block table sequencer around one table RAM.
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | mode, req_bytes, payload_addr
//  rsp     | out | valid/ready | status, granted_addr
// One request at a time. Allocate: accept, then scan the table entries from the last one down,
// and on a split move the entries above the fit up and write the new entry. Release:
// accept, scan entries from the first one up, read the next and previous neighbours, and on
// a merge move the later entries down. The result is held in the response register.
// Range errors answer in the cycle after the accept.
// After reset the init state writes the initial free block; req.ready is low then.
// A response waiting on rsp.ready holds off the next request.
`default_nettype none
module first_fit_block_allocator_core #(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   ffa_req_if.sink   req_chan,
   ffa_rsp_if.source rsp_chan
);
   localparam int AW   = $clog2(ARENA_BYTES + 1);
   localparam int IW   = $clog2(MAX_BLOCKS);
   localparam int CNTW = $clog2(MAX_BLOCKS + 1);
   localparam int CW   = ((AW > ffa_pkg::PADDR_W) ? AW : ffa_pkg::PADDR_W) + 1;
   localparam int EW   = 2 * AW + 1;

   ffa_pkg::state_type state_ff, state_in;

   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [CNTW-1:0] found_ff, found_in;
   logic [1:0]      del_ff, del_in;
   logic            nxt_merge_ff, nxt_merge_in;
   logic [ffa_pkg::REQ_W-1:0] rbytes_ff, rbytes_in;
   logic [AW-1:0]   hdr_ff, hdr_in;
   logic [AW-1:0]   cur_start_ff, cur_start_in;
   logic [AW-1:0]   cur_size_ff, cur_size_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ffa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ffa_pkg::GRANT_W-1:0]   rsp_addr_ff, rsp_addr_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;
   logic [AW-1:0] r_start, r_size;
   logic          r_free;

   logic          accept;
   logic          fit_exact, fit_split, hit, is_last, has_next, has_prev, prv_merge;
   logic          p_over, p_under, s0_in_range;
   logic [CNTW:0] s0;
   logic [1:0]    del_now;
   logic [AW-1:0] split_size;

   logic                         done;
   logic [ffa_pkg::STATUS_W-1:0] done_status;
   logic [AW-1:0]                done_addr;

   ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[IW-1:0]),
      .rd_data (rd_data)
   );

   assign r_start = rd_data[2*AW:AW+1];
   assign r_size  = rd_data[AW:1];
   assign r_free  = rd_data[0];

   assign req_chan.ready = (state_ff == ffa_pkg::S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.granted_addr = rsp_addr_ff;

   // entry checks on the entry whose data is on the read port this cycle
   assign fit_exact  = r_free && (CW'(r_size) == CW'(rbytes_ff));
   assign fit_split  = r_free && (CW'(r_size) >= CW'(rbytes_ff) + CW'(HEADER_BYTES))
                       && (count_ff < CNTW'(MAX_BLOCKS));
   assign split_size = AW'(CW'(r_size) - CW'(rbytes_ff) - CW'(HEADER_BYTES));
   assign hit        = (r_start == hdr_ff);
   assign is_last    = (idx_ff == count_ff - 1'b1);
   assign has_next   = ((CNTW+1)'(found_ff) + 1'b1) < (CNTW+1)'(count_ff);
   assign has_prev   = (found_ff != '0);
   assign prv_merge  = has_prev && r_free;
   assign del_now    = 2'(nxt_merge_ff) + 2'(prv_merge);
   assign s0         = (CNTW+1)'(found_ff) + 1'b1 + (CNTW+1)'(nxt_merge_ff);
   assign s0_in_range = s0 < (CNTW+1)'(count_ff);
   assign p_over     = CW'(req_chan.payload_addr) > CW'(ARENA_BYTES);
   assign p_under    = CW'(req_chan.payload_addr) < CW'(HEADER_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::S_INIT: state_in = ffa_pkg::S_IDLE;
         ffa_pkg::S_IDLE: begin
            if (accept) begin
               if (req_chan.mode == ffa_pkg::MODE_ALLOC) begin
                  state_in = ffa_pkg::S_ASCAN;
               end else if (!p_over && !p_under) begin
                  state_in = ffa_pkg::S_RSCAN;
               end
            end
         end
         ffa_pkg::S_ASCAN: begin
            if (fit_exact) begin
               state_in = ffa_pkg::S_IDLE;
            end else if (fit_split) begin
               state_in = (idx_ff + 1'b1 == count_ff) ? ffa_pkg::S_IPUT : ffa_pkg::S_ISHIFT;
            end else if (idx_ff == '0) begin
               state_in = ffa_pkg::S_IDLE;
            end
         end
         ffa_pkg::S_ISHIFT: begin
            if (idx_ff == found_ff + 1'b1) begin
               state_in = ffa_pkg::S_IPUT;
            end
         end
         ffa_pkg::S_IPUT: state_in = ffa_pkg::S_IDLE;
         ffa_pkg::S_RSCAN: begin
            if (hit) begin
               state_in = r_free ? ffa_pkg::S_IDLE : ffa_pkg::S_RNXT;
            end else if (is_last) begin
               state_in = ffa_pkg::S_IDLE;
            end
         end
         ffa_pkg::S_RNXT: state_in = ffa_pkg::S_RPRV;
         ffa_pkg::S_RPRV: begin
            state_in = (del_now != '0 && s0_in_range) ? ffa_pkg::S_DSHIFT : ffa_pkg::S_IDLE;
         end
         ffa_pkg::S_DSHIFT: begin
            if (is_last) begin
               state_in = ffa_pkg::S_IDLE;
            end
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   // datapath and table writes
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      del_in       = del_ff;
      nxt_merge_in = nxt_merge_ff;
      rbytes_in    = rbytes_ff;
      hdr_in       = hdr_ff;
      cur_start_in = cur_start_ff;
      cur_size_in  = cur_size_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = rd_data;
      done         = 1'b0;
      done_status  = ffa_pkg::ST_NOSPACE;
      done_addr    = '0;
      case (state_ff)
         ffa_pkg::S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {AW'(0), AW'(ARENA_BYTES - HEADER_BYTES), 1'b1};
            count_in = CNTW'(1);
         end
         ffa_pkg::S_IDLE: begin
            if (accept) begin
               rbytes_in = req_chan.req_bytes;
               hdr_in    = AW'(CW'(req_chan.payload_addr) - CW'(HEADER_BYTES));
               if (req_chan.mode == ffa_pkg::MODE_ALLOC) begin
                  idx_in = count_ff - 1'b1;
               end else if (p_over) begin
                  done        = 1'b1;
                  done_status = ffa_pkg::ST_RANGE;
               end else if (p_under) begin
                  done        = 1'b1;
                  done_status = ffa_pkg::ST_INVALID;
               end else begin
                  idx_in = '0;
               end
            end
         end
         ffa_pkg::S_ASCAN: begin
            if (fit_exact) begin
               wr_en       = 1'b1;
               wr_data     = {r_start, r_size, 1'b0};
               done        = 1'b1;
               done_status = ffa_pkg::ST_ALLOC;
               done_addr   = AW'(r_start + AW'(HEADER_BYTES));
            end else if (fit_split) begin
               wr_en        = 1'b1;
               wr_data      = {r_start, split_size, 1'b1};
               found_in     = idx_ff;
               cur_start_in = AW'(r_start + AW'(HEADER_BYTES) + split_size);
               idx_in       = count_ff - 1'b1;
            end else if (idx_ff == '0) begin
               done        = 1'b1;
               done_status = ffa_pkg::ST_NOSPACE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ffa_pkg::S_ISHIFT: begin
            // move entry idx up by one, walking down toward the insert point
            wr_en   = 1'b1;
            wr_addr = IW'(idx_ff + 1'b1);
            wr_data = rd_data;
            idx_in  = idx_ff - 1'b1;
         end
         ffa_pkg::S_IPUT: begin
            wr_en       = 1'b1;
            wr_addr     = IW'(found_ff + 1'b1);
            wr_data     = {cur_start_ff, AW'(rbytes_ff), 1'b0};
            count_in    = count_ff + 1'b1;
            done        = 1'b1;
            done_status = ffa_pkg::ST_ALLOC;
            done_addr   = AW'(cur_start_ff + AW'(HEADER_BYTES));
         end
         ffa_pkg::S_RSCAN: begin
            if (hit) begin
               if (r_free) begin
                  done        = 1'b1;
                  done_status = ffa_pkg::ST_INVALID;
               end else begin
                  found_in     = idx_ff;
                  cur_start_in = r_start;
                  cur_size_in  = r_size;
                  idx_in       = idx_ff + 1'b1;
               end
            end else if (is_last) begin
               done        = 1'b1;
               done_status = ffa_pkg::ST_INVALID;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ffa_pkg::S_RNXT: begin
            nxt_merge_in = has_next && r_free;
            if (has_next && r_free) begin
               cur_size_in = AW'(cur_size_ff + AW'(HEADER_BYTES) + r_size);
            end
            idx_in = found_ff - 1'b1;
         end
         ffa_pkg::S_RPRV: begin
            wr_en  = 1'b1;
            del_in = del_now;
            if (prv_merge) begin
               wr_addr = IW'(found_ff - 1'b1);
               wr_data = {r_start, AW'(r_size + AW'(HEADER_BYTES) + cur_size_ff), 1'b1};
            end else begin
               wr_addr = found_ff[IW-1:0];
               wr_data = {cur_start_ff, cur_size_ff, 1'b1};
            end
            if (del_now != '0 && s0_in_range) begin
               idx_in = CNTW'(s0);
            end else begin
               count_in    = count_ff - CNTW'(del_now);
               done        = 1'b1;
               done_status = ffa_pkg::ST_RELEASED;
            end
         end
         ffa_pkg::S_DSHIFT: begin
            // close the gap left by merged entries
            wr_en   = 1'b1;
            wr_addr = IW'(idx_ff - CNTW'(del_ff));
            wr_data = rd_data;
            if (is_last) begin
               count_in    = count_ff - CNTW'(del_ff);
               done        = 1'b1;
               done_status = ffa_pkg::ST_RELEASED;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status;
         rsp_addr_in   = (done_status == ffa_pkg::ST_ALLOC) ?
                         ffa_pkg::GRANT_W'(done_addr) : '0;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::S_INIT;
         count_ff     <= CNTW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      del_ff        <= del_in;
      nxt_merge_ff  <= nxt_merge_in;
      rbytes_ff     <= rbytes_in;
      hdr_ff        <= hdr_in;
      cur_start_ff  <= cur_start_in;
      cur_size_ff   <= cur_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end
endmodule
`default_nettype wire

// File: src/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: src/ffa_checker.sv
// Port-level assertions for the allocator core, bound into the allocator core module.
`default_nettype none
module ffa_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [ffa_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [ffa_pkg::GRANT_W-1:0]  rsp_granted_addr
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ffa_pkg::ST_ALLOC || rsp_status == ffa_pkg::ST_NOSPACE ||
                     rsp_status == ffa_pkg::ST_RELEASED || rsp_status == ffa_pkg::ST_RANGE ||
                     rsp_status == ffa_pkg::ST_INVALID))
      else $error("bad response status");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffa_pkg::ST_ALLOC) |-> (rsp_granted_addr == '0))
      else $error("nonzero address on failed request");

   // a stalled response blocks the next request
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !(rsp_valid && !rsp_ready))
      else $error("request accepted while response stalled");

   a_init_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");
endmodule

bind first_fit_block_allocator_core ffa_checker u_ffa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_granted_addr (rsp_chan.granted_addr)
);
`default_nettype wire
